// ===== sv/json_subset_token_lexer_core_macros.svh =====
// assertion helpers used by the lexer checker
`ifndef JSON_SUBSET_TOKEN_LEXER_CORE_MACROS_SVH
`define JSON_SUBSET_TOKEN_LEXER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define JSLEX_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer check failed: same-cycle rule");

// next-cycle implication, disabled while in reset
`define JSLEX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer check failed: next-cycle rule");

`endif

// ===== sv/jslex_pkg.sv =====
package jslex_pkg;

  // offset counter width and result queue size
  localparam int unsigned OffsetBits = 16;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoAw     = $clog2(FifoDepth);

  typedef logic [OffsetBits-1:0] offset_t;

  typedef enum logic [3:0] {
    KindOpenObj  = 4'd0,
    KindCloseObj = 4'd1,
    KindOpenArr  = 4'd2,
    KindCloseArr = 4'd3,
    KindComma    = 4'd4,
    KindColon    = 4'd5,
    KindQuote    = 4'd6,
    KindValue    = 4'd7,
    KindEnd      = 4'd8,
    KindNone     = 4'd9
  } token_kind_e;

  typedef enum logic [1:0] {
    ModeIdle   = 2'd0,
    ModeString = 2'd1,
    ModeBare   = 2'd2
  } scan_mode_e;

  typedef enum logic [1:0] {
    ErrNone  = 2'd0,
    ErrToken = 2'd1,
    ErrEmpty = 2'd2,
    ErrLong  = 2'd3
  } error_code_e;

  // escape phase: none, after backslash, hex digits of \u counted from 2 to 5
  localparam logic [2:0] EscNone      = 3'd0;
  localparam logic [2:0] EscBackslash = 3'd1;
  localparam logic [2:0] EscHexFirst  = 3'd2;
  localparam logic [2:0] EscHexLast   = 3'd5;

  // characters
  localparam logic [7:0] ChCtrlLimit = 8'h20;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChOpenObj   = 8'h7B;
  localparam logic [7:0] ChCloseObj  = 8'h7D;
  localparam logic [7:0] ChOpenArr   = 8'h5B;
  localparam logic [7:0] ChCloseArr  = 8'h5D;
  localparam logic [7:0] ChComma     = 8'h2C;
  localparam logic [7:0] ChColon     = 8'h3A;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChLowB      = 8'h62;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChLowN      = 8'h6E;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowU      = 8'h75;

  typedef struct packed {
    logic        in_string;
    scan_mode_e  mode;
    logic [2:0]  esc;
    token_kind_e prev;
    offset_t     vstart;
    offset_t     vcount;
    offset_t     pos;
    logic        failed;
  } lex_state_t;

  localparam lex_state_t LexReset = '{
    in_string: 1'b0,
    mode:      ModeIdle,
    esc:       EscNone,
    prev:      KindNone,
    vstart:    '0,
    vcount:    '0,
    pos:       '0,
    failed:    1'b0
  };

  typedef struct packed {
    token_kind_e kind;
    logic [15:0] offset;
    logic [15:0] length;
    error_code_e err;
    logic        last;
  } token_t;

endpackage

// ===== sv/json_subset_token_lexer_core.sv =====
// channel | direction | handshake              | payload
// --------+-----------+------------------------+---------------------------------------
// in      | input     | in_valid_i, in_stall_o | data_byte_i, end_mark_i
// out     | output    | out_valid_o, out_stall_i | token_kind_o, token_offset_o,
//         |           |                        | token_length_o, error_code_o, last_in_run_o
//
// One input byte is taken per cycle while in_stall_o is low; its tokens land in a 4-entry result queue.
// A byte yields zero, one or two tokens; the single output port drains one per cycle while out_stall_i is low,
// so a byte that closes a value and also emits a delimiter queues both tokens, which leave one after the other.
// in_stall_o rises while the queue holds more than two tokens.
// Reset clears the lexer state and the queue; no clearing pass is needed.
module json_subset_token_lexer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_mark_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] token_offset_o,
  output logic [15:0] token_length_o,
  output logic [1:0]  error_code_o,
  output logic        last_in_run_o
);

  typedef struct packed {
    jslex_pkg::lex_state_t st;
    logic                  hit;
    jslex_pkg::token_t     tok;
  } fresh_t;

  function automatic jslex_pkg::token_t mk_tok(jslex_pkg::token_kind_e k,
                                               jslex_pkg::offset_t off,
                                               jslex_pkg::offset_t len,
                                               jslex_pkg::error_code_e e);
    jslex_pkg::token_t t;
    t.kind   = k;
    t.offset = 16'(off);
    t.length = 16'(len);
    t.err    = e;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic is_hex(logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic jslex_pkg::lex_state_t fail_state(jslex_pkg::lex_state_t s);
    jslex_pkg::lex_state_t r;
    r        = s;
    r.failed = 1'b1;
    r.mode   = jslex_pkg::ModeIdle;
    r.esc    = jslex_pkg::EscNone;
    return r;
  endfunction

  // byte seen outside any value
  function automatic fresh_t fresh_byte(jslex_pkg::lex_state_t s, logic [7:0] b);
    fresh_t             f;
    jslex_pkg::offset_t one;
    one   = jslex_pkg::offset_t'(1);
    f.st  = s;
    f.hit = 1'b0;
    f.tok = mk_tok(jslex_pkg::KindEnd, s.pos, '0, jslex_pkg::ErrToken);
    if (b == 8'h00) begin
      f.hit = 1'b1;
      f.st  = fail_state(s);
    end else if ((!s.in_string || b == jslex_pkg::ChQuote) &&
                 (b == jslex_pkg::ChSpace || b == jslex_pkg::ChTab ||
                  b == jslex_pkg::ChLf || b == jslex_pkg::ChCr)) begin
      f.hit = 1'b0;
    end else if ((!s.in_string || b == jslex_pkg::ChQuote) &&
                 (b == jslex_pkg::ChOpenObj || b == jslex_pkg::ChCloseObj ||
                  b == jslex_pkg::ChOpenArr || b == jslex_pkg::ChCloseArr ||
                  b == jslex_pkg::ChComma || b == jslex_pkg::ChColon ||
                  b == jslex_pkg::ChQuote)) begin
      f.hit = 1'b1;
      case (b)
        jslex_pkg::ChOpenObj:  f.st.prev = jslex_pkg::KindOpenObj;
        jslex_pkg::ChCloseObj: f.st.prev = jslex_pkg::KindCloseObj;
        jslex_pkg::ChOpenArr:  f.st.prev = jslex_pkg::KindOpenArr;
        jslex_pkg::ChCloseArr: f.st.prev = jslex_pkg::KindCloseArr;
        jslex_pkg::ChComma:    f.st.prev = jslex_pkg::KindComma;
        jslex_pkg::ChColon:    f.st.prev = jslex_pkg::KindColon;
        default: begin
          f.st.prev      = jslex_pkg::KindQuote;
          f.st.in_string = ~s.in_string;
        end
      endcase
      f.tok = mk_tok(f.st.prev, s.pos, one, jslex_pkg::ErrNone);
    end else if (s.prev == jslex_pkg::KindQuote) begin
      // first byte of a string value
      f.st.vstart = s.pos;
      if (b < jslex_pkg::ChCtrlLimit) begin
        f.hit = 1'b1;
        f.st  = fail_state(f.st);
      end else begin
        f.st.mode   = jslex_pkg::ModeString;
        f.st.vcount = one;
        f.st.esc    = (b == jslex_pkg::ChBackslash) ? jslex_pkg::EscBackslash
                                                    : jslex_pkg::EscNone;
      end
    end else if (s.prev == jslex_pkg::KindColon) begin
      // first byte of a bare value
      f.st.mode   = jslex_pkg::ModeBare;
      f.st.esc    = jslex_pkg::EscNone;
      f.st.vstart = s.pos;
      f.st.vcount = one;
    end else begin
      f.hit = 1'b1;
      f.st  = fail_state(s);
    end
    return f;
  endfunction

  jslex_pkg::lex_state_t st_q, st_d, st_mid;
  jslex_pkg::token_t     r0, r1;
  jslex_pkg::token_t     val_tok;
  fresh_t                fr;
  logic [1:0]            n_push;
  logic                  in_xfer, out_xfer;
  logic                  str_close, bare_close, esc_open;

  jslex_pkg::token_t                 fifo_q [jslex_pkg::FifoDepth];
  logic [jslex_pkg::FifoAw-1:0]      wr_q, rd_q;
  logic [jslex_pkg::FifoAw:0]        cnt_q;

  // handshake
  assign in_stall_o  = cnt_q > (jslex_pkg::FifoAw+1)'(jslex_pkg::FifoDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign out_xfer    = out_valid_o & ~out_stall_i;

  // value close detection
  assign esc_open   = st_q.esc >= jslex_pkg::EscBackslash && st_q.esc <= jslex_pkg::EscHexLast;
  assign str_close  = st_q.mode == jslex_pkg::ModeString && !esc_open &&
                      data_byte_i == jslex_pkg::ChQuote;
  assign bare_close = st_q.mode == jslex_pkg::ModeBare &&
                      (data_byte_i == jslex_pkg::ChCloseArr ||
                       data_byte_i == jslex_pkg::ChCloseObj ||
                       data_byte_i == jslex_pkg::ChComma ||
                       data_byte_i == jslex_pkg::ChSpace ||
                       (data_byte_i >= 8'h09 && data_byte_i <= 8'h0D));

  assign val_tok = mk_tok(jslex_pkg::KindValue, st_q.vstart, st_q.vcount, jslex_pkg::ErrNone);

  // state after an open value is closed, before the byte is tokenized afresh
  always_comb begin
    st_mid = st_q;
    if (str_close || bare_close) begin
      st_mid.prev = jslex_pkg::KindValue;
      st_mid.mode = jslex_pkg::ModeIdle;
      st_mid.esc  = jslex_pkg::EscNone;
    end
  end

  assign fr = fresh_byte(st_mid, data_byte_i);

  // per-byte lexer step
  always_comb begin
    st_d   = st_q;
    r0     = val_tok;
    r1     = fr.tok;
    n_push = 2'd0;
    if (in_xfer) begin
      if (end_mark_i) begin
        st_d = jslex_pkg::LexReset;
        if (!st_q.failed) begin
          n_push = 2'd1;
          if (st_q.pos == '0) begin
            r0 = mk_tok(jslex_pkg::KindEnd, '0, '0, jslex_pkg::ErrEmpty);
          end else if (st_q.mode != jslex_pkg::ModeIdle || st_q.esc != jslex_pkg::EscNone) begin
            r0 = mk_tok(jslex_pkg::KindEnd, st_q.vstart, '0, jslex_pkg::ErrToken);
          end else begin
            r0 = mk_tok(jslex_pkg::KindEnd, st_q.pos - jslex_pkg::offset_t'(1), '0,
                        jslex_pkg::ErrNone);
          end
        end
      end else if (!st_q.failed) begin
        if (&st_q.pos) begin
          n_push = 2'd1;
          r0     = mk_tok(jslex_pkg::KindEnd, st_q.pos, '0, jslex_pkg::ErrLong);
          st_d   = fail_state(st_q);
        end else begin
          if (str_close || bare_close) begin
            st_d   = fr.st;
            n_push = fr.hit ? 2'd2 : 2'd1;
          end else if (st_q.mode == jslex_pkg::ModeString) begin
            r0 = mk_tok(jslex_pkg::KindEnd, st_q.vstart, '0, jslex_pkg::ErrToken);
            if (st_q.esc == jslex_pkg::EscBackslash) begin
              if (data_byte_i == jslex_pkg::ChQuote || data_byte_i == jslex_pkg::ChBackslash ||
                  data_byte_i == jslex_pkg::ChSlash || data_byte_i == jslex_pkg::ChLowB ||
                  data_byte_i == jslex_pkg::ChLowF || data_byte_i == jslex_pkg::ChLowN ||
                  data_byte_i == jslex_pkg::ChLowR || data_byte_i == jslex_pkg::ChLowT) begin
                st_d.vcount = st_q.vcount + jslex_pkg::offset_t'(1);
                st_d.esc    = jslex_pkg::EscNone;
              end else if (data_byte_i == jslex_pkg::ChLowU) begin
                st_d.vcount = st_q.vcount + jslex_pkg::offset_t'(1);
                st_d.esc    = jslex_pkg::EscHexFirst;
              end else begin
                n_push = 2'd1;
                st_d   = fail_state(st_q);
              end
            end else if (esc_open) begin
              // hex digits of a unicode escape
              if (is_hex(data_byte_i)) begin
                st_d.vcount = st_q.vcount + jslex_pkg::offset_t'(1);
                st_d.esc    = (st_q.esc == jslex_pkg::EscHexLast) ? jslex_pkg::EscNone
                                                                  : st_q.esc + 3'd1;
              end else begin
                n_push = 2'd1;
                st_d   = fail_state(st_q);
              end
            end else if (data_byte_i < jslex_pkg::ChCtrlLimit) begin
              n_push = 2'd1;
              st_d   = fail_state(st_q);
            end else begin
              st_d.vcount = st_q.vcount + jslex_pkg::offset_t'(1);
              st_d.esc    = (data_byte_i == jslex_pkg::ChBackslash) ? jslex_pkg::EscBackslash
                                                                    : jslex_pkg::EscNone;
            end
          end else if (st_q.mode == jslex_pkg::ModeBare) begin
            if (data_byte_i == 8'h00) begin
              n_push = 2'd1;
              r0     = mk_tok(jslex_pkg::KindEnd, st_q.vstart, '0, jslex_pkg::ErrToken);
              st_d   = fail_state(st_q);
            end else begin
              st_d.vcount = st_q.vcount + jslex_pkg::offset_t'(1);
            end
          end else begin
            st_d   = fr.st;
            r0     = fr.tok;
            n_push = fr.hit ? 2'd1 : 2'd0;
          end
          st_d.pos = st_q.pos + jslex_pkg::offset_t'(1);
        end
      end
    end
    r0.last = n_push == 2'd1;
    r1.last = 1'b1;
  end

  // lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= jslex_pkg::LexReset;
    end else begin
      st_q <= st_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_q] <= r0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_q + (jslex_pkg::FifoAw)'(1)] <= r1;
    end
  end

  // result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + (jslex_pkg::FifoAw)'(n_push);
      rd_q  <= rd_q + (jslex_pkg::FifoAw)'(out_xfer);
      cnt_q <= cnt_q + (jslex_pkg::FifoAw+1)'(n_push) - (jslex_pkg::FifoAw+1)'(out_xfer);
    end
  end

  // output payload from queue head
  assign token_kind_o   = fifo_q[rd_q].kind;
  assign token_offset_o = fifo_q[rd_q].offset;
  assign token_length_o = fifo_q[rd_q].length;
  assign error_code_o   = fifo_q[rd_q].err;
  assign last_in_run_o  = fifo_q[rd_q].last;

endmodule

// ===== sv/jslex_checker.sv =====
`include "json_subset_token_lexer_core_macros.svh"

module jslex_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  token_kind_o,
  input logic [15:0] token_offset_o,
  input logic [15:0] token_length_o,
  input logic [1:0]  error_code_o,
  input logic        last_in_run_o
);

  // a stalled result stays offered
  `JSLEX_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // a stalled result keeps its payload
  `JSLEX_ASSERT_NEXT(a_out_payload_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    $stable(token_kind_o) && $stable(token_offset_o) && $stable(token_length_o) &&
    $stable(error_code_o) && $stable(last_in_run_o))

  // only end results carry an error code
  `JSLEX_ASSERT_IMPLY(a_err_on_end_only, clk_i, rst_ni,
    out_valid_o && token_kind_o != jslex_pkg::KindEnd, error_code_o == jslex_pkg::ErrNone)

  // an error closes the run of its byte and has no length
  `JSLEX_ASSERT_IMPLY(a_err_is_last, clk_i, rst_ni,
    out_valid_o && error_code_o != jslex_pkg::ErrNone,
    last_in_run_o && token_length_o == 16'd0)

  // the input side only stalls while results are waiting
  `JSLEX_ASSERT_IMPLY(a_stall_has_backlog, clk_i, rst_ni, in_stall_o, out_valid_o)

endmodule

bind json_subset_token_lexer_core jslex_checker u_jslex_checker (.*);
